/* design/ftavg_pkg.sv */
// ----------------------------------------------------------------------------
// ftavg_pkg
// shared types and constants of the frame time averager
// ----------------------------------------------------------------------------
package ftavg_pkg;

   localparam int TS_W    = 64;
   localparam int TICK_W  = 32;
   localparam int RATE_W  = 16;
   localparam int CSR_A_W = 1;

   localparam logic [CSR_A_W-1:0] REG_TICKS_PER_SECOND = 1'b0;
   localparam logic [CSR_A_W-1:0] REG_MIN_FRAME_TICKS  = 1'b1;

   localparam logic FUNC_TICK    = 1'b0;
   localparam logic FUNC_RESTART = 1'b1;

   typedef struct packed {
      logic load;
      logic restart;
      logic commit;
   } el_ctl_type;

endpackage

/* design/ftavg_ram.sv */
// ----------------------------------------------------------------------------
// ftavg_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module ftavg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/ftavg_elapsed.sv */
// ----------------------------------------------------------------------------
// ftavg_elapsed
// bit-serial timestamp subtractor holding the last frame time
// ----------------------------------------------------------------------------
module ftavg_elapsed
   import ftavg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  el_ctl_type        ctl,
   input  logic [TS_W-1:0]   timestamp,
   output logic [TICK_W-1:0] elapsed,
   output logic              done
);

   localparam int CNT_W = $clog2(TS_W);

   logic [TS_W-1:0]   ts_ff, ts_in;
   logic [TS_W-1:0]   last_ff, last_in;
   logic [TICK_W-1:0] diff_ff, diff_in;
   logic              borrow_ff, borrow_in;
   logic              hi_nz_ff, hi_nz_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              bit_d;
   logic              hi_phase;

   always_comb begin
      bit_d     = ts_ff[0] ^ last_ff[0] ^ borrow_ff;
      hi_phase  = cnt_ff >= CNT_W'(TICK_W);
      ts_in     = ts_ff;
      last_in   = last_ff;
      diff_in   = diff_ff;
      borrow_in = borrow_ff;
      hi_nz_in  = hi_nz_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (ctl.restart) begin
         last_in = timestamp;
      end else if (ctl.commit) begin
         last_in = ts_ff;
      end else if (ctl.load) begin
         ts_in     = timestamp;
         borrow_in = 1'b0;
         hi_nz_in  = 1'b0;
         cnt_in    = '0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         // rotate both operands so they come back whole after a full pass
         ts_in     = {ts_ff[0], ts_ff[TS_W-1:1]};
         last_in   = {last_ff[0], last_ff[TS_W-1:1]};
         borrow_in = (~ts_ff[0] & last_ff[0]) | (~(ts_ff[0] ^ last_ff[0]) & borrow_ff);
         if (hi_phase) begin
            hi_nz_in = hi_nz_ff | bit_d;
         end else begin
            diff_in = {bit_d, diff_ff[TICK_W-1:1]};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(TS_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff   <= '0;
         busy_ff   <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
         borrow_ff <= 1'b0;
         hi_nz_ff  <= 1'b0;
      end else begin
         last_ff   <= last_in;
         busy_ff   <= busy_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
         borrow_ff <= borrow_in;
         hi_nz_ff  <= hi_nz_in;
      end
      ts_ff   <= ts_in;
      diff_ff <= diff_in;
   end

   assign elapsed = hi_nz_ff ? '1 : diff_ff;
   assign done    = done_ff;

endmodule

/* design/ftavg_div.sv */
// ----------------------------------------------------------------------------
// ftavg_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ftavg_div #(
   parameter int DIVIDEND_W = 39,
   parameter int DIVISOR_W  = 7,
   parameter int QUOT_W     = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic [QUOT_W-1:0]     quotient,
   output logic                  done
);

   localparam int CNT_W = $clog2(DIVIDEND_W);

   logic [DIVIDEND_W-1:0] quot_ff, quot_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  div_ff, div_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W:0]    rem_sh;
   logic [DIVISOR_W:0]    rem_sub;
   logic                  fits;

   always_comb begin
      rem_sh  = {rem_ff, quot_ff[DIVIDEND_W-1]};
      rem_sub = rem_sh - {1'b0, div_ff};
      fits    = rem_sh >= {1'b0, div_ff};
      quot_in = quot_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
         quot_in = {quot_ff[DIVIDEND_W-2:0], fits};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign quotient = quot_ff[QUOT_W-1:0];
   assign done     = done_ff;

endmodule

/* design/frame_time_averager_top.sv */
// a restart transaction gives no result; a frame tick runs the bit-serial
// timestamp subtractor, the minimum frame check (a tick below it gives no
// result), the window gate and, when the sample enters the window, the add
// and the one-bit-per-cycle average divider; one transaction at a time, a
// request is taken only when idle and a result waits while the result side stalls
// reset: synchronous, active high; clears all counters, sums and the last time
// ----------------------------------------------------------------------------
// frame_time_averager_top
// frame time and frame rate tracker on a free-running tick counter
// ----------------------------------------------------------------------------
module frame_time_averager_top
   import ftavg_pkg::*;
#(
   parameter int SAMPLE_DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [63:0]        req_tdata,   // timestamp
   input  logic               req_tuser,   // func
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [79:0]        rsp_tdata,   // frame_ticks, avg_frame_ticks, frame_rate
   output logic               rsp_tuser,   // sample_taken
   input  logic               csr_we,
   input  logic [CSR_A_W-1:0] csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam int AW = $clog2(SAMPLE_DEPTH);
   localparam int CW = $clog2(SAMPLE_DEPTH + 1);
   localparam int SW = TICK_W + CW;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUB,
      ST_CHECK,
      ST_GATE,
      ST_ADD,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type         state_ff, state_in;
   logic [TICK_W-1:0] tps_ff, tps_in;
   logic [TICK_W-1:0] min_ff, min_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     wp_ff, wp_in;
   logic [SW-1:0]     sum_ff, sum_in;
   logic [TICK_W-1:0] avg_ff, avg_in;
   logic [RATE_W-1:0] frames_ff, frames_in;
   logic [TICK_W:0]   acc_ff, acc_in;
   logic [RATE_W-1:0] rate_ff, rate_in;
   logic [TICK_W-1:0] dev_ff, dev_in;
   logic              taken_ff, taken_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [79:0]       rsp_data_ff, rsp_data_in;
   logic              rsp_user_ff, rsp_user_in;

   logic              req_acc;
   el_ctl_type        el_ctl;
   logic [TICK_W-1:0] elapsed;
   logic              el_done;
   logic              wr_en;
   logic [TICK_W-1:0] old_sample;
   logic              div_start;
   logic [TICK_W-1:0] div_quot;
   logic              div_done;
   logic [RATE_W-1:0] frames_inc;
   logic [TICK_W:0]   acc_sum;

   assign req_tready = state_ff == ST_IDLE;
   assign req_acc    = req_tvalid & req_tready;

   ftavg_elapsed u_elapsed (
      .clock     (clock),
      .reset     (reset),
      .ctl       (el_ctl),
      .timestamp (req_tdata),
      .elapsed   (elapsed),
      .done      (el_done)
   );

   ftavg_ram #(
      .WIDTH (TICK_W),
      .DEPTH (SAMPLE_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (elapsed),
      .rd_addr (wp_ff),
      .rd_data (old_sample)
   );

   ftavg_div #(
      .DIVIDEND_W (SW),
      .DIVISOR_W  (CW),
      .QUOT_W     (TICK_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_in),
      .divisor  (count_ff),
      .quotient (div_quot),
      .done     (div_done)
   );

   always_comb begin
      state_in     = state_ff;
      tps_in       = tps_ff;
      min_in       = min_ff;
      count_in     = count_ff;
      wp_in        = wp_ff;
      sum_in       = sum_ff;
      avg_in       = avg_ff;
      frames_in    = frames_ff;
      acc_in       = acc_ff;
      rate_in      = rate_ff;
      dev_in       = dev_ff;
      taken_in     = taken_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      el_ctl       = '0;
      wr_en        = 1'b0;
      div_start    = 1'b0;
      frames_inc   = (frames_ff == '1) ? frames_ff : frames_ff + 1'b1;
      acc_sum      = acc_ff + {1'b0, elapsed};

      if (csr_we) begin
         case (csr_index)
            REG_TICKS_PER_SECOND: tps_in = csr_wdata;
            REG_MIN_FRAME_TICKS:  min_in = csr_wdata;
            default:              tps_in = tps_ff;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_tuser == FUNC_RESTART) begin
                  el_ctl.restart = 1'b1;
               end else begin
                  el_ctl.load = 1'b1;
                  state_in    = ST_SUB;
               end
            end
         end
         ST_SUB: begin
            if (el_done) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (min_ff != '0 && elapsed < min_ff) begin
               state_in = ST_IDLE;
            end else begin
               el_ctl.commit = 1'b1;
               dev_in = (elapsed >= avg_ff) ? elapsed - avg_ff : avg_ff - elapsed;
               if (acc_sum > {1'b0, tps_ff}) begin
                  rate_in   = frames_inc;
                  frames_in = '0;
                  acc_in    = '0;
               end else begin
                  frames_in = frames_inc;
                  acc_in    = acc_sum;
               end
               state_in = ST_GATE;
            end
         end
         ST_GATE: begin
            taken_in = dev_ff < tps_ff;
            if (dev_ff < tps_ff) begin
               wr_en = 1'b1;
               wp_in = (wp_ff == AW'(SAMPLE_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
               if (count_ff == CW'(SAMPLE_DEPTH)) begin
                  sum_in = sum_ff - {{(SW-TICK_W){1'b0}}, old_sample};
               end else begin
                  count_in = count_ff + 1'b1;
               end
               state_in = ST_ADD;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_ADD: begin
            sum_in    = sum_ff + {{(SW-TICK_W){1'b0}}, elapsed};
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               avg_in   = div_quot;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {rate_ff, avg_ff, elapsed};
               rsp_user_in  = taken_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tps_ff       <= 32'd10000000;
         min_ff       <= '0;
         count_ff     <= '0;
         wp_ff        <= '0;
         sum_ff       <= '0;
         avg_ff       <= '0;
         frames_ff    <= '0;
         acc_ff       <= '0;
         rate_ff      <= '0;
         taken_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tps_ff       <= tps_in;
         min_ff       <= min_in;
         count_ff     <= count_in;
         wp_ff        <= wp_in;
         sum_ff       <= sum_in;
         avg_ff       <= avg_in;
         frames_ff    <= frames_in;
         acc_ff       <= acc_in;
         rate_ff      <= rate_in;
         taken_ff     <= taken_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dev_ff      <= dev_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(SAMPLE_DEPTH))
      else $error("sample count beyond window depth");

   a_avg_needs_samples: assert property (@(posedge clock) disable iff (reset)
      (avg_ff != '0) |-> (count_ff != '0))
      else $error("non-zero average with empty window");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide step");

   a_taken_has_sample: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (count_ff != '0))
      else $error("sample reported taken with empty window");
`endif

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for frame_time_averager_top: a directed table of frame
// ticks, restarts and limit settings, then random frame streams under several
// limit settings, every result checked against table values or an in-bench frame tracker
// ----------------------------------------------------------------------------
module testbench;
   import ftavg_pkg::*;

   localparam int HIST_DEPTH    = 64;
   localparam int SETTLE_CYCLES = 150;
   localparam int LONG_HOLD     = 800;

   typedef struct packed {
      logic [TICK_W-1:0] frame_ticks;
      logic [TICK_W-1:0] avg_ticks;
      logic [RATE_W-1:0] rate;
      logic              taken;
   } frame_result_type;

   typedef enum logic {ROW_FRAME, ROW_SETUP} row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic              func;
      logic [TS_W-1:0]   stamp;
      logic [31:0]       tps;
      logic [31:0]       min_ticks;
      logic              known;
      frame_result_type  known_res;
   } plan_row_type;

   localparam frame_result_type NO_RESULT = '0;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [63:0]        req_tdata = '0;  // timestamp
   logic               req_tuser = 1'b0;  // func
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [79:0]        rsp_tdata;  // frame_ticks, avg_frame_ticks, frame_rate
   logic               rsp_tuser;  // sample_taken
   logic               csr_we = 1'b0;
   logic [CSR_A_W-1:0] csr_index = '0;
   logic [31:0]        csr_wdata = '0;

   frame_time_averager_top #(.SAMPLE_DEPTH(HIST_DEPTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // frame tracker state
   logic [31:0]     cfg_tps = 32'd10_000_000;
   logic [31:0]     cfg_min = 32'd0;
   logic [TS_W-1:0] prev_stamp = '0;
   logic [31:0]     hist [HIST_DEPTH];
   int              hist_count = 0;
   logic [63:0]     hist_sum = '0;
   logic [31:0]     mean_ticks = '0;
   logic [15:0]     frames_sec = '0;
   logic [63:0]     sec_accum = '0;
   logic [15:0]     rate_now = '0;

   frame_result_type pending_frames [$];
   logic [TS_W-1:0]  stamp_now = '0;
   bit               quiet = 1'b0;
   bit               long_hold_done = 1'b0;
   int               hold_cycles = 0;
   int               failures = 0;
   int               accepted = 0;
   int               restarts = 0;
   int               locked_out = 0;
   int               samples_in = 0;
   int               results_seen = 0;

   function automatic bit track_frame(input logic func, input logic [TS_W-1:0] stamp,
                                      output frame_result_type res);
      logic [TS_W-1:0] span;
      logic [31:0]     elapsed;
      logic [31:0]     dev;
      bit              taken;
      res = NO_RESULT;
      if (func == FUNC_RESTART) begin
         prev_stamp = stamp;
         return 1'b0;
      end
      span = stamp - prev_stamp;
      elapsed = (span > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : span[31:0];
      if (cfg_min != 0 && elapsed < cfg_min) return 1'b0;
      prev_stamp = stamp;
      dev = (elapsed >= mean_ticks) ? elapsed - mean_ticks : mean_ticks - elapsed;
      taken = dev < cfg_tps;
      if (taken) begin
         if (hist_count >= HIST_DEPTH) hist_sum -= 64'(hist[HIST_DEPTH-1]);
         else hist_count++;
         for (int i = HIST_DEPTH - 1; i > 0; i--) hist[i] = hist[i-1];
         hist[0] = elapsed;
         hist_sum += 64'(elapsed);
      end
      if (frames_sec != 16'hFFFF) frames_sec++;
      sec_accum += 64'(elapsed);
      if (sec_accum > 64'(cfg_tps)) begin
         rate_now = frames_sec;
         frames_sec = '0;
         sec_accum = '0;
      end
      mean_ticks = (hist_count != 0) ? 32'(hist_sum / 64'(hist_count)) : 32'd0;
      res = '{elapsed, mean_ticks, rate_now, taken};
      return 1'b1;
   endfunction

   task automatic offer(input logic func, input logic [TS_W-1:0] stamp,
                        output bit gives, output frame_result_type res);
      int gap;
      if (!quiet && $urandom_range(5) == 0) begin
         gap = $urandom_range(16, 1);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= stamp;
      req_tuser  <= func;
      do @(posedge clock); while (!req_tready);
      accepted++;
      gives = track_frame(func, stamp, res);
      if (func == FUNC_RESTART) restarts++;
      else if (!gives) locked_out++;
      else if (res.taken) samples_in++;
   endtask

   // wait for the block to go idle, including a tick that gives no result
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_limits(input logic [31:0] tps, input logic [31:0] min_ticks);
      settle();
      csr_we    <= 1'b1;
      csr_index <= REG_TICKS_PER_SECOND;
      csr_wdata <= tps;
      @(posedge clock);
      csr_index <= REG_MIN_FRAME_TICKS;
      csr_wdata <= min_ticks;
      @(posedge clock);
      csr_we  <= 1'b0;
      cfg_tps = tps;
      cfg_min = min_ticks;
   endtask

   task automatic random_phase(input logic [31:0] tps, input logic [31:0] min_ticks,
                               input int lo, input int hi, input int items);
      int               counted;
      int               pick;
      logic             func;
      bit               gives;
      frame_result_type res;
      program_limits(tps, min_ticks);
      counted = 0;
      while (counted < items) begin
         pick = $urandom_range(99);
         func = FUNC_TICK;
         if (pick < 4) begin
            func = FUNC_RESTART;
            stamp_now += 64'($urandom_range(hi));
         end else if (pick < 7) begin
            func = 1'($urandom_range(1));
            stamp_now = {$urandom, $urandom};
         end else if (pick < 10) begin
            stamp_now += (pick == 7) ? {$urandom, $urandom} : 64'($urandom);
         end else if (pick < 12) begin
            stamp_now = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(hi));
         end else begin
            stamp_now += 64'($urandom_range(hi, lo));
         end
         offer(func, stamp_now, gives, res);
         if (gives) pending_frames.push_back(res);
         counted++;
      end
   endtask

   task automatic check_field(input string label, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t %s mismatch: expected %h actual %h", $time, label, want, got);
         failures++;
      end
   endtask

   // result side: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_cycles > 0) begin
            hold_cycles--;
         end else if (!long_hold_done && results_seen >= 60) begin
            long_hold_done = 1'b1;
            hold_cycles = LONG_HOLD;
         end else if (!quiet && $urandom_range(7) == 0) begin
            hold_cycles = $urandom_range(16, 1);
         end
         rsp_tready <= (hold_cycles == 0);
      end
   end

   always @(posedge clock) begin
      frame_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_frames.size() == 0) begin
            $display("%0t unexpected result transaction: expected none actual %h %b",
                     $time, rsp_tdata, rsp_tuser);
            failures++;
         end else begin
            want = pending_frames.pop_front();
            check_field("frame_ticks", want.frame_ticks, rsp_tdata[31:0]);
            check_field("avg_frame_ticks", want.avg_ticks, rsp_tdata[63:32]);
            check_field("frame_rate", 32'(want.rate), 32'(rsp_tdata[79:64]));
            check_field("sample_taken", 32'(want.taken), 32'(rsp_tuser));
         end
      end
   end

   plan_row_type plan [0:21] = '{
      '{ROW_FRAME, FUNC_TICK,    64'h0,                     '0, '0, 1'b1,
        '{32'h0, 32'd0, 16'd0, 1'b1}},
      '{ROW_FRAME, FUNC_RESTART, 64'hFFFF_FFFF_FFFF_FFF0,   '0, '0, 1'b0, NO_RESULT},
      '{ROW_FRAME, FUNC_TICK,    64'h10,                    '0, '0, 1'b1,
        '{32'd32, 32'd16, 16'd0, 1'b1}},
      '{ROW_FRAME, FUNC_TICK,    64'hFFFF_FFFF_FFFF_FFFF,   '0, '0, 1'b1,
        '{32'hFFFF_FFFF, 32'd16, 16'd3, 1'b0}},
      '{ROW_FRAME, FUNC_RESTART, 64'h0,                     '0, '0, 1'b0, NO_RESULT},
      '{ROW_FRAME, FUNC_TICK,    64'd100,                   '0, '0, 1'b0, NO_RESULT},
      '{ROW_FRAME, FUNC_TICK,    64'd100,                   '0, '0, 1'b0, NO_RESULT},
      '{ROW_SETUP, FUNC_TICK,    64'h0, 32'd1,         32'd0,         1'b0, NO_RESULT},
      '{ROW_FRAME, FUNC_TICK,    64'd150,                   '0, '0, 1'b0, NO_RESULT},
      '{ROW_FRAME, FUNC_TICK,    64'd200,                   '0, '0, 1'b0, NO_RESULT},
      '{ROW_SETUP, FUNC_TICK,    64'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, NO_RESULT},
      '{ROW_FRAME, FUNC_TICK,    64'd201,                   '0, '0, 1'b0, NO_RESULT},
      '{ROW_FRAME, FUNC_TICK,    64'h0000_0001_0000_00C7,   '0, '0, 1'b0, NO_RESULT},
      '{ROW_FRAME, FUNC_TICK,    64'h0000_0101_0000_00C7,   '0, '0, 1'b0, NO_RESULT},
      '{ROW_SETUP, FUNC_TICK,    64'h0, 32'd1000,      32'd50,        1'b0, NO_RESULT},
      '{ROW_FRAME, FUNC_TICK,    64'h0000_0101_0000_00F8,   '0, '0, 1'b0, NO_RESULT},
      '{ROW_FRAME, FUNC_TICK,    64'h0000_0101_0000_00F9,   '0, '0, 1'b0, NO_RESULT},
      '{ROW_FRAME, FUNC_RESTART, 64'hAAAA_AAAA_AAAA_AAAA,   '0, '0, 1'b0, NO_RESULT},
      '{ROW_FRAME, FUNC_TICK,    64'hAAAA_AAAA_AAAA_AAE1,   '0, '0, 1'b0, NO_RESULT},
      '{ROW_FRAME, FUNC_RESTART, 64'h5555_5555_5555_5555,   '0, '0, 1'b0, NO_RESULT},
      '{ROW_FRAME, FUNC_TICK,    64'h5555_5555_5555_558C,   '0, '0, 1'b0, NO_RESULT},
      '{ROW_SETUP, FUNC_TICK,    64'h0, 32'd10_000_000, 32'd0,        1'b0, NO_RESULT}
   };

   initial begin
      bit               gives;
      frame_result_type res;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_SETUP) begin
            program_limits(plan[i].tps, plan[i].min_ticks);
         end else begin
            offer(plan[i].func, plan[i].stamp, gives, res);
            if (gives) pending_frames.push_back(plan[i].known ? plan[i].known_res : res);
         end
      end

      stamp_now = prev_stamp;
      random_phase(32'd1000, 32'd0, 40, 60, 170);
      random_phase(32'd1000, 32'd45, 30, 70, 150);
      random_phase(32'd1, 32'd0, 40, 40, 100);
      random_phase(32'd10_000_000, 32'd0, 160_000, 175_000, 150);
      settle();
      quiet = 1'b1;
      random_phase(32'd2000, 32'd10, 20, 80, 180);
      settle();

      $display("run covered %0d input transactions (%0d restarts, %0d held off by the lock)",
               accepted, restarts, locked_out);
      $display("%0d result transactions checked, %0d samples entered the window",
               results_seen, samples_in);
      if (failures == 0) begin
         $display("frame_time_averager_top verification clean");
      end else begin
         $display("frame_time_averager_top verification failed");
      end
      $finish;
   end

   initial begin
      #18_000_000;
      $display("frame_time_averager_top verification failed");
      $finish;
   end

endmodule

/* frame_time_averager_top.f */
design/ftavg_pkg.sv
design/ftavg_ram.sv
design/ftavg_elapsed.sv
design/ftavg_div.sv
design/frame_time_averager_top.sv
verif/testbench.sv
